/* hdl/serial_decimal_to_hex_led_scanner_defines.svh */
// assertion macros for the serial decimal to hex led scanner checker
// no dependencies; included by the checker file only
`ifndef SERIAL_DECIMAL_TO_HEX_LED_SCANNER_DEFINES_SVH
`define SERIAL_DECIMAL_TO_HEX_LED_SCANNER_DEFINES_SVH

// clocked property, ignored while reset is asserted
`define SDHL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked through reset as well
`define SDHL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/sdhl_pkg.sv */
// shared types, constants and lookup functions for the led scanner
// no dependencies
`default_nettype none

package sdhl_pkg;

  // number of scanned digits and width of the scan position
  localparam int NUM_DIGITS = 4;
  localparam int POS_W      = 3;

  // input operations
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // characters the parser looks for
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // active-low digit enables by scan position
  localparam logic [7:0] SEL_DIG0 = 8'hdf;
  localparam logic [7:0] SEL_DIG1 = 8'hef;
  localparam logic [7:0] SEL_DIG2 = 8'h7f;
  localparam logic [7:0] SEL_DIG3 = 8'hbf;

  // segment bits
  localparam logic [7:0] SEG_A = 8'h02;
  localparam logic [7:0] SEG_B = 8'h04;
  localparam logic [7:0] SEG_C = 8'h40;
  localparam logic [7:0] SEG_D = 8'h10;
  localparam logic [7:0] SEG_E = 8'h08;
  localparam logic [7:0] SEG_F = 8'h01;
  localparam logic [7:0] SEG_G = 8'h20;

  localparam logic [7:0] GLYPH_ZERO = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;

  // value that leaves the display unchanged
  localparam logic [15:0] HIDE_VALUE = 16'hffff;

  // four received characters, entry 0 first
  typedef logic [3:0][7:0] group_t;

  // parser result
  typedef struct packed {
    logic        show;
    logic [15:0] value;
  } parse_res_t;

  function automatic logic [7:0] select_code(input logic [1:0] pos);
    logic [7:0] code;
    case (pos)
      2'd0:    code = SEL_DIG0;
      2'd1:    code = SEL_DIG1;
      2'd2:    code = SEL_DIG2;
      default: code = SEL_DIG3;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    case (nib)
      4'h0:    g = 8'h5F;
      4'h1:    g = 8'h44;
      4'h2:    g = 8'h3E;
      4'h3:    g = 8'h76;
      4'h4:    g = 8'h65;
      4'h5:    g = 8'h73;
      4'h6:    g = 8'h7B;
      4'h7:    g = 8'h46;
      4'h8:    g = 8'h7F;
      4'h9:    g = 8'h77;
      4'ha:    g = 8'h6F;
      4'hb:    g = 8'h79;
      4'hc:    g = 8'h1B;
      4'hd:    g = 8'h7C;
      4'he:    g = 8'h3B;
      default: g = 8'h2B;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/sdhl_parse.sv */
// decimal group parser: whitespace, optional sign, up to four digits, then /4
// depends on sdhl_pkg
`default_nettype none

module sdhl_parse (
  input  sdhl_pkg::group_t     group,
  output sdhl_pkg::parse_res_t res
);
  import sdhl_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t      phase;
  logic        neg;
  logic [13:0] acc;
  logic [16:0] acc_x10;
  logic [11:0] mag;
  logic [15:0] value;
  logic [7:0]  c;
  logic        is_blank;
  logic        is_digit;
  logic        is_sign;
  logic [3:0]  dval;

  // walk the four characters left to right
  always_comb begin
    phase   = PH_SKIP;
    neg     = 1'b0;
    acc     = '0;
    acc_x10 = '0;
    c       = '0;
    is_blank = 1'b0;
    is_digit = 1'b0;
    is_sign  = 1'b0;
    dval     = '0;
    for (int k = 0; k < 4; k++) begin
      c        = group[k];
      is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
      dval     = 4'(c - CH_ZERO);
      acc_x10  = {acc, 3'b000} + {2'b00, acc, 1'b0} + {13'd0, dval};
      case (phase)
        PH_SKIP: begin
          if (is_blank) begin
            phase = PH_SKIP;
          end else if (is_sign) begin
            neg   = (c == CH_MINUS);
            phase = PH_DIGITS;
          end else if (is_digit) begin
            acc   = {10'd0, dval};
            phase = PH_DIGITS;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            acc = acc_x10[13:0];
          end else begin
            phase = PH_DONE;
          end
        end
        default: phase = PH_DONE;
      endcase
    end
  end

  // divide magnitude by 4, then apply sign (truncates toward zero)
  assign mag   = acc[13:2];
  assign value = neg ? 16'(-{4'd0, mag}) : {4'd0, mag};

  assign res.value = value;
  assign res.show  = (value != HIDE_VALUE);

endmodule

`default_nettype wire

/* hdl/serial_decimal_to_hex_led_scanner.sv */
// Four-digit hex display multiplexer fed by a serial decimal stream. Each input
// transaction is a received character or a scan tick; one is accepted every
// cycle while in_stall is low. Every fourth character closes a group that is
// parsed as a signed decimal, divided by 4 and shown as four hex digits (unless
// the 16-bit value is 0xFFFF). A scan tick yields one output transaction, digit
// select plus segment pattern, passing through the input register and then the
// output register; characters yield none. in_stall rises only when a registered
// tick meets a full, stalled output register.
// depends on sdhl_pkg and sdhl_parse
`default_nettype none

module serial_decimal_to_hex_led_scanner (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_digit_select,
  output logic [7:0] out_segment_bits
);
  import sdhl_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_opcode_r;
  logic [7:0] s1_rx_byte_r;

  // block state
  logic [1:0]      char_count_r, char_count_nxt;
  logic [7:0]      char_store_r [3];
  logic [7:0]      pattern_r [4];
  logic [POS_W-1:0] scan_pos_r, scan_pos_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_sel_r;
  logic [7:0] out_seg_r;

  logic       fire;
  logic       fire_char;
  logic       fire_tick;
  logic       group_done;
  group_t     group;
  parse_res_t pres;

  // stall only when a tick cannot move into a busy output register
  assign in_stall  = s1_valid_r && (s1_opcode_r == OP_TICK) && out_valid_r && out_stall;
  assign fire      = s1_valid_r && !in_stall;
  assign fire_char = fire && (s1_opcode_r == OP_CHAR);
  assign fire_tick = fire && (s1_opcode_r == OP_TICK);
  assign group_done = fire_char && (char_count_r == 2'd3);

  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_opcode_r  <= in_opcode;
      s1_rx_byte_r <= in_rx_byte;
    end
  end

  // group assembly and parse
  assign group[0] = char_store_r[0];
  assign group[1] = char_store_r[1];
  assign group[2] = char_store_r[2];
  assign group[3] = s1_rx_byte_r;

  sdhl_parse u_parse (
    .group (group),
    .res   (pres)
  );

  // character counter
  always_comb begin
    char_count_nxt = char_count_r;
    if (fire_char) begin
      char_count_nxt = group_done ? 2'd0 : 2'(char_count_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r <= '0;
      char_store_r <= '{default: 8'h00};
    end else begin
      char_count_r <= char_count_nxt;
      if (fire_char && !group_done) begin
        char_store_r[char_count_r] <= s1_rx_byte_r;
      end
    end
  end

  // digit patterns, most significant nibble to digit 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '{default: GLYPH_ZERO};
    end else if (group_done && pres.show) begin
      pattern_r[0] <= hex_glyph(pres.value[15:12]);
      pattern_r[1] <= hex_glyph(pres.value[11:8]);
      pattern_r[2] <= hex_glyph(pres.value[7:4]);
      pattern_r[3] <= hex_glyph(pres.value[3:0]);
    end
  end

  // scan position wraps after the last digit
  always_comb begin
    scan_pos_nxt = scan_pos_r;
    if (fire_tick) begin
      if (scan_pos_r >= POS_W'(NUM_DIGITS - 1)) begin
        scan_pos_nxt = '0;
      end else begin
        scan_pos_nxt = POS_W'(scan_pos_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
    end else begin
      scan_pos_r <= scan_pos_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_tick) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_tick) begin
      out_sel_r <= select_code(scan_pos_r[1:0]);
      out_seg_r <= pattern_r[scan_pos_r[1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = out_sel_r;
  assign out_segment_bits = out_seg_r;

endmodule

`default_nettype wire

/* hdl/sdhl_checker.sv */
// port-level checks for the led scanner, bound to the top level
// depends on sdhl_pkg and serial_decimal_to_hex_led_scanner_defines.svh
`default_nettype none
`include "serial_decimal_to_hex_led_scanner_defines.svh"

module sdhl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_digit_select
);
  import sdhl_pkg::*;

  logic sel_legal;

  // one of the four digit enables
  assign sel_legal = (out_digit_select == SEL_DIG0) || (out_digit_select == SEL_DIG1) ||
                     (out_digit_select == SEL_DIG2) || (out_digit_select == SEL_DIG3);

  // output register is empty right after reset
  `SDHL_ASSERT(a_empty_after_reset, $rose(rst_n) |-> !out_valid, "output valid after reset")

  // a pending result is held while stalled
  `SDHL_ASSERT(a_out_hold, (out_valid && out_stall) |=> out_valid, "stalled result dropped")

  // input only backs up behind a stalled output
  `SDHL_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without cause")

  // every result carries a legal digit select
  `SDHL_ASSERT(a_select_code, out_valid |-> sel_legal, "bad digit select")

endmodule

bind serial_decimal_to_hex_led_scanner sdhl_checker u_sdhl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_digit_select (out_digit_select)
);

`default_nettype wire
